// File: rtl/mcdf_pkg.sv
`timescale 1ns / 1ps
package mcdf_pkg;
  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W = 24;
  localparam int CONF_W = 16;
  localparam int TAG_W = 16;
  localparam int ID_W = 32;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_DET   = 2'd1,
    ACT_END   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_INC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_OFS  = 2'd2;

  typedef struct packed {
    action_t            action;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   z;
    logic [CONF_W-1:0]  conf;
    logic [TAG_W-1:0]   tag;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   z;
    logic [CONF_W-1:0]  conf;
    logic [TAG_W-1:0]   tag;
    logic [ID_W-1:0]    id;
    logic               ovf;
    logic               last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DEC,
    ST_EMIT,
    ST_EMIT_WAIT
  } state_t;
endpackage

// File: rtl/multi_camera_detection_fusion.sv
`timescale 1ns / 1ps
// sequence: each command passes through the queue, then start_camera is handled in idle;
// detection steps through read, compare and decide per prior entry scanned, then read and decide
// end_frame: an emit and an emit-wait step per emitted beat, stalling while pop stays low
// throughput: one item at a time in the back end; a 4-beat queue takes items meanwhile
// reset: synchronous active-low rst_n clears counts, marks, queue and config to defaults
// entry storage is undefined after reset and needs no clearing pass
module multi_camera_detection_fusion import mcdf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               in_action,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  input  logic signed [POS_W-1:0]  in_pos_z,
  input  logic [CONF_W-1:0]        in_confidence,
  input  logic [TAG_W-1:0]         in_tag,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [POS_W-1:0]  out_x,
  output logic signed [POS_W-1:0]  out_y,
  output logic signed [POS_W-1:0]  out_z,
  output logic [CONF_W-1:0]        out_confidence,
  output logic [TAG_W-1:0]         out_tag,
  output logic [ID_W-1:0]          out_detection_id,
  output logic                     out_overflowed,
  output logic                     out_last,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);
  logic [15:0] ovl_dist_r;
  logic [7:0]  id_inc_r;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop, res_valid;
  res_t res;
  logic id_load;

  assign in_cmd = '{action: action_t'(in_action), x: in_pos_x, y: in_pos_y,
                    z: in_pos_z, conf: in_confidence, tag: in_tag};
  assign id_load = cfg_we && (cfg_index == CFG_ID_OFS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovl_dist_r <= 16'd500;
      id_inc_r   <= 8'd1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_OVERLAP) ovl_dist_r <= cfg_data[15:0];
      if (cfg_index == CFG_ID_INC) id_inc_r <= cfg_data[7:0];
    end
  end

  mcdf_front u_front (
    .clk, .rst_n, .in_valid(push), .in_full(full), .in_cmd,
    .q_valid, .q_pop, .q_cmd
  );

  mcdf_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
    .overlap_distance(ovl_dist_r), .id_increment(id_inc_r),
    .id_load, .id_value(cfg_data),
    .res_valid, .res_ready(pop), .res
  );

  assign empty            = !res_valid;
  assign out_x            = res.x;
  assign out_y            = res.y;
  assign out_z            = res.z;
  assign out_confidence   = res.conf;
  assign out_tag          = res.tag;
  assign out_detection_id = res.id;
  assign out_overflowed   = res.ovf;
  assign out_last         = res.last;
endmodule

// File: rtl/mcdf_front.sv
`timescale 1ns / 1ps
module mcdf_front import mcdf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_full,
  input  cmd_t              in_cmd,
  output logic              q_valid,
  input  logic              q_pop,
  output cmd_t              q_cmd
);
  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              push_ok, keep;

  // unused action codes never enter the queue
  assign keep    = (in_cmd.action != ACT_NONE);
  assign in_full = (cnt_r == QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
  assign push_ok = in_valid && !in_full && keep;
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !(q_pop && q_valid)) cnt_nxt = cnt_r + 1'b1;
    else if (!push_ok && q_pop && q_valid) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) wp_r <= wp_r + 1'b1;
      if (q_pop && q_valid) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wp_r] <= in_cmd;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QDEPTH)) else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !q_valid) else $error("valid on empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != (QPTR_W+1)'(QDEPTH)) |-> (QPTR_W'(wp_r - rp_r) == cnt_r[QPTR_W-1:0]))
    else $error("pointer gap mismatch");
endmodule

// File: rtl/mcdf_back.sv
`timescale 1ns / 1ps
module mcdf_back import mcdf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  cmd_t               q_cmd,
  input  logic [15:0]        overlap_distance,
  input  logic [7:0]         id_increment,
  input  logic               id_load,
  input  logic [ID_W-1:0]    id_value,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res
);
  logic [POS_W-1:0]  ex_r [MAX_ENTRIES];
  logic [POS_W-1:0]  ey_r [MAX_ENTRIES];
  logic [POS_W-1:0]  ez_r [MAX_ENTRIES];
  logic [CONF_W-1:0] ec_r [MAX_ENTRIES];
  logic [TAG_W-1:0]  et_r [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] repl_r;

  state_t            st_r, st_nxt;
  logic [CNT_W-1:0]  count_r, prior_r, j_r;
  logic              fovf_r, ovl_r, bet_r;
  logic [ID_W-1:0]   next_id_r, next_id_nxt;
  logic [POS_W-1:0]  rx_r, ry_r, rz_r;
  logic [CONF_W-1:0] rc_r;
  logic [TAG_W-1:0]  rt_r;
  logic [50:0]       d2_r;
  logic [31:0]       thr_r;
  logic              cmp_ok_r;
  res_t              res_r;
  logic              res_v_r, res_v_nxt;

  logic signed [POS_W:0] dx, dy, dz;
  logic [POS_W-1:0] ax, ay, az;
  logic [47:0] sx, sy, sz;
  logic [IDX_W-1:0] ji;
  logic hit, wr_app, wr_rep, scan_done, load_res, emit_last;

  assign ji = j_r[IDX_W-1:0];
  assign dx = $signed({q_cmd.x[POS_W-1], q_cmd.x}) - $signed({rx_r[POS_W-1], rx_r});
  assign dy = $signed({q_cmd.y[POS_W-1], q_cmd.y}) - $signed({ry_r[POS_W-1], ry_r});
  assign dz = $signed({q_cmd.z[POS_W-1], q_cmd.z}) - $signed({rz_r[POS_W-1], rz_r});
  // magnitudes fit in POS_W bits
  assign ax = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
  assign ay = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
  assign az = dz[POS_W] ? POS_W'(-dz) : dz[POS_W-1:0];
  assign sx = ax * ax;
  assign sy = ay * ay;
  assign sz = az * az;
  assign hit = (d2_r < 51'(thr_r));
  assign scan_done = (j_r >= prior_r);

  assign load_res  = (st_r == ST_EMIT_WAIT) && (!res_v_r || res_ready);
  assign emit_last = (j_r + 1'b1 == count_r);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid) begin
        unique case (q_cmd.action)
          ACT_DET: st_nxt = ST_READ;
          ACT_END: st_nxt = (count_r == '0) ? ST_IDLE : ST_EMIT;
          default: st_nxt = ST_IDLE;
        endcase
      end
      ST_READ: st_nxt = scan_done ? ST_DEC : ST_CMP;
      ST_CMP:  st_nxt = ST_DEC;
      ST_DEC:  st_nxt = (!cmp_ok_r || wr_rep) ? ST_IDLE : ST_READ;
      ST_EMIT: st_nxt = ST_EMIT_WAIT;
      ST_EMIT_WAIT: if (load_res) begin
        st_nxt = emit_last ? ST_IDLE : ST_EMIT;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    res_v_nxt = res_v_r;
    if (res_v_r && res_ready) res_v_nxt = 1'b0;
    if (load_res) res_v_nxt = 1'b1;
  end

  always_comb begin
    next_id_nxt = next_id_r;
    if (id_load) next_id_nxt = id_value;
    else if (load_res) next_id_nxt = next_id_r + ID_W'(id_increment);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      count_r   <= '0;
      prior_r   <= '0;
      fovf_r    <= 1'b0;
      repl_r    <= '0;
      next_id_r <= '0;
      j_r       <= '0;
      ovl_r     <= 1'b0;
      bet_r     <= 1'b0;
      cmp_ok_r  <= 1'b0;
      res_v_r   <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      res_v_r   <= res_v_nxt;
      next_id_r <= next_id_nxt;
      unique case (st_r)
        ST_IDLE: begin
          j_r <= '0; ovl_r <= 1'b0; bet_r <= 1'b0; cmp_ok_r <= 1'b0;
          if (q_valid) begin
            if (q_cmd.action == ACT_START) begin
              prior_r <= count_r;
              repl_r  <= '0;
            end else if (q_cmd.action == ACT_END && count_r == '0) begin
              prior_r <= '0; fovf_r <= 1'b0; repl_r <= '0;
            end
          end
        end
        ST_CMP: begin
          d2_r  <= 51'(sx) + 51'(sy) + 51'(sz);
          thr_r <= 32'(overlap_distance) * 32'(overlap_distance);
          cmp_ok_r <= 1'b1;
        end
        ST_DEC: begin
          if (!cmp_ok_r) begin
            // scan finished: append if allowed
            if (!ovl_r || bet_r) begin
              if (count_r < CNT_W'(MAX_ENTRIES)) count_r <= count_r + 1'b1;
              else fovf_r <= 1'b1;
            end
          end else begin
            cmp_ok_r <= 1'b0;
            if (hit) begin
              ovl_r <= 1'b1;
              if (q_cmd.conf > rc_r) begin
                bet_r <= 1'b1;
                if (!repl_r[ji]) repl_r[ji] <= 1'b1;
              end
            end
            if (!wr_rep) j_r <= j_r + 1'b1;
          end
        end
        ST_EMIT_WAIT: if (load_res) begin
          if (emit_last) begin
            count_r <= '0; prior_r <= '0; fovf_r <= 1'b0; repl_r <= '0;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // entry read register and result register
  always_ff @(posedge clk) begin
    rx_r <= ex_r[ji];
    ry_r <= ey_r[ji];
    rz_r <= ez_r[ji];
    rc_r <= ec_r[ji];
    rt_r <= et_r[ji];
    if (load_res) begin
      res_r.x    <= rx_r;
      res_r.y    <= ry_r;
      res_r.z    <= rz_r;
      res_r.conf <= rc_r;
      res_r.tag  <= rt_r;
      res_r.id   <= next_id_r;
      res_r.ovf  <= fovf_r;
      res_r.last <= emit_last;
    end
  end

  assign wr_rep = (st_r == ST_DEC) && cmp_ok_r && hit && (q_cmd.conf > rc_r) && !repl_r[ji];
  assign wr_app = (st_r == ST_DEC) && !cmp_ok_r && (!ovl_r || bet_r)
                  && (count_r < CNT_W'(MAX_ENTRIES));

  always_ff @(posedge clk) begin
    if (wr_rep || wr_app) begin
      ex_r[wr_rep ? ji : count_r[IDX_W-1:0]] <= q_cmd.x;
      ey_r[wr_rep ? ji : count_r[IDX_W-1:0]] <= q_cmd.y;
      ez_r[wr_rep ? ji : count_r[IDX_W-1:0]] <= q_cmd.z;
      ec_r[wr_rep ? ji : count_r[IDX_W-1:0]] <= q_cmd.conf;
      et_r[wr_rep ? ji : count_r[IDX_W-1:0]] <= q_cmd.tag;
    end
  end

  always_comb begin
    q_pop = 1'b0;
    unique case (st_r)
      ST_IDLE: q_pop = q_valid && (q_cmd.action != ACT_DET)
                       && !(q_cmd.action == ACT_END && count_r != '0);
      ST_DEC:  q_pop = q_valid && (!cmp_ok_r || wr_rep);
      ST_EMIT_WAIT: q_pop = q_valid && load_res && emit_last;
      default: q_pop = 1'b0;
    endcase
  end

  assign res_valid = res_v_r;
  assign res = res_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES)) else $error("entry count overflow");
  a_prior_le: assert property (@(posedge clk) disable iff (!rst_n)
    prior_r <= count_r) else $error("prior above count");
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.last && $rose(res_valid)) |-> (count_r == '0))
    else $error("store not cleared after last beat");
endmodule

// File: bench/multi_camera_detection_fusion_tb.sv
`timescale 1ns / 1ps
module multi_camera_detection_fusion_tb;
  import mcdf_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic [CONF_W-1:0] conf;
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   id;
    logic              ovf;
    logic              last;
  } fused_t;

  class fusion_scoreboard;
    logic [POS_W-1:0]  ex[MAX_ENTRIES];
    logic [POS_W-1:0]  ey[MAX_ENTRIES];
    logic [POS_W-1:0]  ez[MAX_ENTRIES];
    logic [CONF_W-1:0] ec[MAX_ENTRIES];
    logic [TAG_W-1:0]  et[MAX_ENTRIES];
    bit                repl[MAX_ENTRIES];
    int                count;
    int                prior;
    bit                ovf;
    logic [31:0]       next_id;
    logic [15:0]       ovl_dist;
    logic [7:0]        inc;
    fused_t            pending[$];
    int                errors;

    function void reset_state();
      count = 0;
      prior = 0;
      ovf = 0;
      foreach (repl[i]) repl[i] = 0;
      ovl_dist = 500;
      inc = 1;
      next_id = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
      if (idx == CFG_OVERLAP) ovl_dist = v[15:0];
      else if (idx == CFG_ID_INC) inc = v[7:0];
      else if (idx == CFG_ID_OFS) next_id = v;
    endfunction

    function longint sq(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
      longint d;
      d = longint'($signed(a)) - longint'($signed(b));
      return d * d;
    endfunction

    function void put(int k, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                      logic [POS_W-1:0] z, logic [CONF_W-1:0] c, logic [TAG_W-1:0] t);
      ex[k] = x; ey[k] = y; ez[k] = z; ec[k] = c; et[k] = t;
    endfunction

    function void note_beat(logic [1:0] act, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                            logic [POS_W-1:0] z, logic [CONF_W-1:0] c,
                            logic [TAG_W-1:0] t);
      longint thr, d2;
      bit hit, better;
      fused_t r;
      thr = longint'(ovl_dist) * longint'(ovl_dist);
      case (act)
        ACT_START: begin
          prior = count;
          foreach (repl[i]) repl[i] = 0;
        end
        ACT_DET: begin
          hit = 0;
          better = 0;
          for (int j = 0; j < prior; j++) begin
            d2 = sq(x, ex[j]) + sq(y, ey[j]) + sq(z, ez[j]);
            if (d2 < thr) begin
              hit = 1;
              if (c > ec[j]) begin
                better = 1;
                if (!repl[j]) begin
                  put(j, x, y, z, c, t);
                  repl[j] = 1;
                  return;
                end
              end
            end
          end
          if (!hit || better) begin
            if (count < MAX_ENTRIES) begin
              put(count, x, y, z, c, t);
              repl[count] = 0;
              count++;
            end else ovf = 1;
          end
        end
        ACT_END: begin
          for (int k = 0; k < count; k++) begin
            r = '{ex[k], ey[k], ez[k], ec[k], et[k], next_id, ovf, k + 1 == count};
            pending.insert(pending.size(), r);
            next_id = next_id + inc;
          end
          count = 0;
          prior = 0;
          ovf = 0;
          foreach (repl[i]) repl[i] = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_beat(fused_t got);
      fused_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) begin $error("out_x exp %h got %h", e.x, got.x); errors++; end
      if (got.y !== e.y) begin $error("out_y exp %h got %h", e.y, got.y); errors++; end
      if (got.z !== e.z) begin $error("out_z exp %h got %h", e.z, got.z); errors++; end
      if (got.conf !== e.conf) begin
        $error("out_confidence exp %h got %h", e.conf, got.conf); errors++;
      end
      if (got.tag !== e.tag) begin $error("out_tag exp %h got %h", e.tag, got.tag); errors++; end
      if (got.id !== e.id) begin
        $error("out_detection_id exp %h got %h", e.id, got.id); errors++;
      end
      if (got.ovf !== e.ovf) begin
        $error("out_overflowed exp %b got %b", e.ovf, got.ovf); errors++;
      end
      if (got.last !== e.last) begin
        $error("out_last exp %b got %b", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic push = 0;
  logic full;
  logic [1:0] in_action = ACT_NONE;
  logic signed [POS_W-1:0] in_pos_x = 0, in_pos_y = 0, in_pos_z = 0;
  logic [CONF_W-1:0] in_confidence = 0;
  logic [TAG_W-1:0] in_tag = 0;
  logic empty;
  logic pop = 0;
  logic signed [POS_W-1:0] out_x, out_y, out_z;
  logic [CONF_W-1:0] out_confidence;
  logic [TAG_W-1:0] out_tag;
  logic [ID_W-1:0] out_detection_id;
  logic out_overflowed, out_last;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;

  fusion_scoreboard fusion = new();
  int burst_left = 0;
  int cycles = 0;
  int sent = 0;

  multi_camera_detection_fusion dut (.*);

  always #5 clk = ~clk;

  // result side: stall pattern in phases, including stretches with pop held high
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && !empty && pop)
      fusion.check_beat('{out_x, out_y, out_z, out_confidence, out_tag,
                          out_detection_id, out_overflowed, out_last});
    if (((cycles / 500) % 3) == 0) pop <= 1'b1;
    else pop <= ($urandom_range(0, 3) != 0);
    if (cycles > 1500000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send(logic [1:0] act, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                      logic [POS_W-1:0] z, logic [CONF_W-1:0] c, logic [TAG_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 40);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    push <= 1'b1;
    in_action <= act;
    in_pos_x <= x; in_pos_y <= y; in_pos_z <= z;
    in_confidence <= c; in_tag <= t;
    @(posedge clk);
    while (full) @(posedge clk);
    fusion.note_beat(act, x, y, z, c, t);
    burst_left--;
    sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (fusion.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    fusion.write_reg(idx, v);
    @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] near(logic [POS_W-1:0] b, int r);
    return b + POS_W'($urandom_range(0, 2 * r) - r);
  endfunction

  // one frame: a few cameras seeing roughly the same people
  task automatic random_frame(int ncam, int nppl);
    logic [POS_W-1:0] px[8], py[8], pz[8];
    foreach (px[i]) begin
      px[i] = POS_W'($urandom); py[i] = POS_W'($urandom); pz[i] = POS_W'($urandom);
      if ($urandom_range(0, 1)) begin
        px[i] = POS_W'($urandom_range(0, 3000)); py[i] = POS_W'($urandom_range(0, 3000));
        pz[i] = POS_W'($urandom_range(0, 3000));
      end
    end
    for (int c = 0; c < ncam; c++) begin
      if (c > 0)
        send(ACT_START, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
             CONF_W'($urandom), TAG_W'($urandom));
      for (int p = 0; p < nppl; p++) begin
        int k;
        k = $urandom_range(0, 7);
        if ($urandom_range(0, 9) == 0)
          send(2'($urandom_range(0, 3)), POS_W'($urandom), POS_W'($urandom),
               POS_W'($urandom), CONF_W'($urandom), TAG_W'($urandom));
        else
          send(ACT_DET, near(px[k], 400), near(py[k], 400), near(pz[k], 400),
               CONF_W'($urandom), TAG_W'($urandom));
      end
    end
    send(ACT_END, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
         CONF_W'($urandom), TAG_W'($urandom));
  endtask

  initial begin
    fusion.reset_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, replacement, tie, unused code, empty frame
    send(ACT_END, 0, 0, 0, 0, 0);
    send(ACT_DET, 24'h7fffff, 24'h800000, 24'h7fffff, 16'hffff, 16'hffff);
    send(ACT_DET, 24'h800000, 24'h7fffff, 24'h800000, 16'h0000, 16'h0000);
    send(ACT_DET, 100, 100, 100, 16'h1000, 16'h0001);
    send(ACT_START, 0, 0, 0, 0, 0);
    send(ACT_DET, 120, 90, 100, 16'h2000, 16'h0002);
    send(ACT_DET, 110, 100, 100, 16'h3000, 16'h0003);
    send(ACT_DET, 100, 100, 100, 16'h0500, 16'h0004);
    send(ACT_DET, 600, 100, 100, 16'h9000, 16'h0005);
    send(ACT_DET, 100, 100, 100, 16'h1000, 16'h0006);
    send(ACT_NONE, 24'h555555, 24'haaaaaa, 1, 16'h5555, 16'haaaa);
    send(ACT_START, 0, 0, 0, 0, 0);
    send(ACT_DET, 24'h7fffff, 24'h800000, 24'h7fffff, 16'h0, 16'h1234);
    send(ACT_END, 0, 0, 0, 0, 0);
    drain();

    write_cfg(CFG_OVERLAP, 32'hffff);
    write_cfg(CFG_ID_INC, 32'hff);
    write_cfg(CFG_ID_OFS, 32'hffff_fff0);
    // fill the store past capacity
    for (int i = 0; i < 34; i++)
      send(ACT_DET, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
           CONF_W'($urandom), TAG_W'(i));
    send(ACT_START, 0, 0, 0, 0, 0);
    send(ACT_DET, 0, 0, 0, 16'hffff, 16'hbeef);
    send(ACT_END, 0, 0, 0, 0, 0);
    drain();

    write_cfg(CFG_OVERLAP, 32'd0);
    write_cfg(CFG_ID_INC, 32'd0);
    random_frame(2, 4);
    drain();

    write_cfg(CFG_OVERLAP, 32'd500);
    write_cfg(CFG_ID_INC, 32'd1);
    write_cfg(CFG_ID_OFS, 32'd0);
    while (sent < 100) random_frame($urandom_range(1, 4), $urandom_range(1, 10));
    drain();
    write_cfg(CFG_OVERLAP, $urandom_range(200, 2000));
    write_cfg(CFG_ID_INC, $urandom_range(0, 255));
    write_cfg(CFG_ID_OFS, $urandom);
    while (sent < 130) random_frame($urandom_range(1, 4), $urandom_range(1, 10));
    drain();

    if (fusion.errors == 0 && fusion.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
